// ===== hw/rtl/button_debounce_click_detector_defines.svh =====
// assertion macros used by the button debounce state machine
`ifndef BUTTON_DEBOUNCE_CLICK_DETECTOR_DEFINES_SVH
`define BUTTON_DEBOUNCE_CLICK_DETECTOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// property holds at every clock edge outside reset
`define BDC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("bdc assertion failed");
// consequent holds in the cycle after the antecedent
`define BDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bdc assertion failed");
`else
`define BDC_ASSERT(lbl, clk, rst_n, prop)
`define BDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/bdc_pkg.sv =====
// types and constants of the button debounce and click detector
`timescale 1ns / 1ps
`default_nettype none
package bdc_pkg;
	localparam int TIME_W = 32;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 2;

	// register indexes
	localparam logic [IDX_W-1:0] CFG_ACTIVE_HIGH  = 2'd0;
	localparam logic [IDX_W-1:0] CFG_DEBOUNCE     = 2'd1;
	localparam logic [IDX_W-1:0] CFG_CLICK_MAX    = 2'd2;
	localparam logic [IDX_W-1:0] CFG_DOUBLE_WIN   = 2'd3;

	// register reset values
	localparam logic             RST_ACTIVE_HIGH = 1'b1;
	localparam logic [CFG_W-1:0] RST_DEBOUNCE    = 16'd50;
	localparam logic [CFG_W-1:0] RST_CLICK_MAX   = 16'd1000;
	localparam logic [CFG_W-1:0] RST_DOUBLE_WIN  = 16'd300;

	typedef enum logic [1:0] {
		ST_IDLE       = 2'd0,
		ST_DEBOUNCING = 2'd1,
		ST_PRESSED    = 2'd2,
		ST_RELEASING  = 2'd3
	} state_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_PRESSED  = 3'd1,
		EV_RELEASED = 3'd2,
		EV_CLICKED  = 3'd3,
		EV_DOUBLE   = 3'd4
	} event_t;

	typedef struct packed {
		logic             active_high;
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] click_max_press_ms;
		logic [CFG_W-1:0] double_click_window_ms;
	} cfg_t;
endpackage
`default_nettype wire

// ===== hw/rtl/button_debounce_click_detector.sv =====
// top level of the button debounce and click detector
//
// channel  dir  handshake           payload
// s_*      in   tvalid / tready     tdata: pin_level, now_ms
// m_*      out  tvalid / tready     tdata: event_res, btn_state
// cfg_*    in   cfg_wr_en only      cfg_index, cfg_data
//
// one item per clock unless the output stalls; input, then result register
// the rate is set by the per-item state update in the debounce state machine
// reset clears the state machine, click timing and both pipeline valid flags
// a stalled output holds its result; the input register takes a new item
// when it is empty or as soon as the result register is free or being emptied
`timescale 1ns / 1ps
`default_nettype none
module button_debounce_click_detector (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [39:0]               s_tdata,   // [0] pin_level, [32:1] now_ms
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [7:0]                     m_tdata,   // [2:0] event_res, [4:3] btn_state
	input  wire logic                      cfg_wr_en,
	input  wire logic [bdc_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [bdc_pkg::CFG_W-1:0] cfg_data
);
	import bdc_pkg::*;

	cfg_t              cfg;
	logic              valid_s1;
	logic              pin_s1;
	logic [TIME_W-1:0] now_s1;
	logic              valid_s2;
	event_t            event_s2;
	state_t            state_s2;
	logic              adv;
	event_t            ev;
	state_t            st;

	bdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage one moves on when the result register can take it
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pin_s1 <= s_tdata[0];
			now_s1 <= s_tdata[TIME_W:1];
		end
	end

	bdc_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.pin_level (pin_s1),
		.now_ms    (now_s1),
		.cfg       (cfg),
		.event_res (ev),
		.btn_state (st)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			event_s2 <= ev;
			state_s2 <= st;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, state_s2, event_s2};
endmodule
`default_nettype wire

// ===== hw/rtl/bdc_cfg_regs.sv =====
// configuration registers of the button debounce and click detector
`timescale 1ns / 1ps
`default_nettype none
module bdc_cfg_regs (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [bdc_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [bdc_pkg::CFG_W-1:0] cfg_data,
	output bdc_pkg::cfg_t                  cfg
);
	import bdc_pkg::*;

	cfg_t cfg_q;

	// register writes, low bits of the data kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_high            <= RST_ACTIVE_HIGH;
			cfg_q.debounce_ms            <= RST_DEBOUNCE;
			cfg_q.click_max_press_ms     <= RST_CLICK_MAX;
			cfg_q.double_click_window_ms <= RST_DOUBLE_WIN;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ACTIVE_HIGH: begin
					cfg_q.active_high <= cfg_data[0];
				end
				CFG_DEBOUNCE: begin
					cfg_q.debounce_ms <= cfg_data;
				end
				CFG_CLICK_MAX: begin
					cfg_q.click_max_press_ms <= cfg_data;
				end
				CFG_DOUBLE_WIN: begin
					cfg_q.double_click_window_ms <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule
`default_nettype wire

// ===== hw/rtl/bdc_fsm.sv =====
// debounce state machine and click timing, one item per enabled cycle
`timescale 1ns / 1ps
`default_nettype none
`include "button_debounce_click_detector_defines.svh"
module bdc_fsm (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       pin_level,
	input  wire logic [bdc_pkg::TIME_W-1:0] now_ms,
	input  bdc_pkg::cfg_t                   cfg,
	output bdc_pkg::event_t                 event_res,
	output bdc_pkg::state_t                 btn_state
);
	import bdc_pkg::*;

	state_t              state_q, state_d;
	logic [TIME_W-1:0]   debounce_start_q, debounce_start_d;
	logic [TIME_W-1:0]   press_start_q, press_start_d;
	logic [TIME_W-1:0]   last_click_q, last_click_d;
	logic                pending_q, pending_d;
	event_t              ev;

	logic                down;
	logic [TIME_W-1:0]   deb_elapsed, press_len, click_gap;
	logic                deb_done, press_short, gap_in_win;
	logic                click_armed_now;

	// pressed level and wrapped time differences
	assign down        = cfg.active_high ? pin_level : ~pin_level;
	assign deb_elapsed = now_ms - debounce_start_q;
	assign press_len   = now_ms - press_start_q;
	assign click_gap   = now_ms - last_click_q;
	assign deb_done    = deb_elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms};
	assign press_short = press_len < {{(TIME_W-CFG_W){1'b0}}, cfg.click_max_press_ms};
	assign gap_in_win  = click_gap < {{(TIME_W-CFG_W){1'b0}}, cfg.double_click_window_ms};

	// next state and event
	always_comb begin
		state_d          = state_q;
		debounce_start_d = debounce_start_q;
		press_start_d    = press_start_q;
		last_click_d     = last_click_q;
		pending_d        = pending_q;
		click_armed_now  = 1'b0;
		ev               = EV_NONE;
		case (state_q)
			ST_IDLE: begin
				if (down) begin
					debounce_start_d = now_ms;
					state_d          = ST_DEBOUNCING;
				end
			end
			ST_DEBOUNCING: begin
				if (deb_done) begin
					if (down) begin
						state_d       = ST_PRESSED;
						press_start_d = now_ms;
						ev            = EV_PRESSED;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_PRESSED: begin
				if (!down) begin
					debounce_start_d = now_ms;
					state_d          = ST_RELEASING;
				end
			end
			ST_RELEASING: begin
				if (deb_done) begin
					if (!down) begin
						state_d = ST_IDLE;
						ev      = EV_RELEASED;
						if (press_short) begin
							last_click_d    = now_ms;
							click_armed_now = 1'b1;
							if (gap_in_win && pending_q) begin
								pending_d = 1'b0;
								ev        = EV_DOUBLE;
							end else begin
								pending_d = 1'b1;
							end
						end
					end else begin
						state_d = ST_PRESSED;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// pending click timeout overrides the event, gap is zero if just stamped
		if (pending_d && (click_armed_now ? (cfg.double_click_window_ms == '0)
		                                  : !gap_in_win)) begin
			ev        = EV_CLICKED;
			pending_d = 1'b0;
		end
	end

	// state registers, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			debounce_start_q <= '0;
			press_start_q    <= '0;
			last_click_q     <= '0;
			pending_q        <= 1'b0;
		end else if (en) begin
			state_q          <= state_d;
			debounce_start_q <= debounce_start_d;
			press_start_q    <= press_start_d;
			last_click_q     <= last_click_d;
			pending_q        <= pending_d;
		end
	end

	assign event_res = ev;
	assign btn_state = state_d;

	// checks
	`BDC_ASSERT(a_double_from_release, clk, arst_n,
		!(en && ev == EV_DOUBLE) || (state_q == ST_RELEASING && pending_q))
	`BDC_ASSERT_NEXT(a_press_enters_pressed, clk, arst_n,
		en && ev == EV_PRESSED, state_q == ST_PRESSED && press_start_q == $past(now_ms))
	`BDC_ASSERT(a_state_only_on_item, clk, arst_n,
		!$past(!en) || ($stable(state_q) && $stable(pending_q)))
endmodule
`default_nettype wire

// ===== tb/sv/button_debounce_click_detector_checker.sv =====
// checker that predicts and compares every result of the button debounce and click detector
`timescale 1ns / 1ps
module button_debounce_click_detector_checker (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	input  wire logic                      s_tready,
	input  wire logic [39:0]               s_tdata,   // [0] pin_level, [32:1] now_ms
	input  wire logic                      m_tvalid,
	input  wire logic                      m_tready,
	input  wire logic [7:0]                m_tdata,   // [2:0] event_res, [4:3] btn_state
	input  wire logic                      cfg_wr_en,
	input  wire logic [bdc_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [bdc_pkg::CFG_W-1:0] cfg_data,
	output int                             fail_count,
	output int                             pending
);
	import bdc_pkg::*;

	typedef struct packed {
		state_t st;
		event_t ev;
	} outcome_t;

	// register copy and button state as the block should hold them
	cfg_t       regs;
	state_t     fsm;
	logic [31:0] settle_from;
	logic [31:0] pressed_at;
	logic [31:0] click_at;
	logic       click_armed;
	outcome_t   outcome_q[$];

	// one line per mismatch, counted
	task automatic report(input string what, input int got, input int want);
		fail_count++;
		$display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// next state and event for one pin sample
	task automatic predict_button(input logic pin, input logic [31:0] now, output outcome_t res);
		logic        down;
		event_t      ev;
		logic [31:0] since_settle;
		logic [31:0] held_for;
		logic [31:0] gap;
		down = regs.active_high ? pin : !pin;
		ev = EV_NONE;
		since_settle = now - settle_from;
		case (fsm)
		ST_IDLE: begin
			if (down) begin
				settle_from = now;
				fsm = ST_DEBOUNCING;
			end
		end
		ST_DEBOUNCING: begin
			if (since_settle >= 32'(regs.debounce_ms)) begin
				if (down) begin
					fsm = ST_PRESSED;
					pressed_at = now;
					ev = EV_PRESSED;
				end else begin
					fsm = ST_IDLE;
				end
			end
		end
		ST_PRESSED: begin
			if (!down) begin
				settle_from = now;
				fsm = ST_RELEASING;
			end
		end
		default: begin
			if (since_settle >= 32'(regs.debounce_ms)) begin
				if (!down) begin
					fsm = ST_IDLE;
					ev = EV_RELEASED;
					held_for = now - pressed_at;
					// short press: arm a click or complete a double click
					if (held_for < 32'(regs.click_max_press_ms)) begin
						gap = now - click_at;
						click_at = now;
						if (gap < 32'(regs.double_click_window_ms) && click_armed) begin
							click_armed = 1'b0;
							ev = EV_DOUBLE;
						end else begin
							click_armed = 1'b1;
						end
					end
				end else begin
					fsm = ST_PRESSED;
				end
			end
		end
		endcase
		// a timed-out click overrides whatever else happened
		gap = now - click_at;
		if (click_armed && gap >= 32'(regs.double_click_window_ms)) begin
			ev = EV_CLICKED;
			click_armed = 1'b0;
		end
		res.ev = ev;
		res.st = fsm;
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			regs.active_high = RST_ACTIVE_HIGH;
			regs.debounce_ms = RST_DEBOUNCE;
			regs.click_max_press_ms = RST_CLICK_MAX;
			regs.double_click_window_ms = RST_DOUBLE_WIN;
			fsm = ST_IDLE;
			settle_from = '0;
			pressed_at = '0;
			click_at = '0;
			click_armed = 1'b0;
			outcome_q.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (outcome_q.size() == 0) begin
					report("result item with nothing expected", int'(m_tdata), 0);
				end else begin
					want = outcome_q.pop_front();
					if (m_tdata[2:0] !== want.ev)
						report("event_res", int'(m_tdata[2:0]), int'(want.ev));
					if (m_tdata[4:3] !== want.st)
						report("btn_state", int'(m_tdata[4:3]), int'(want.st));
				end
			end
			if (s_tvalid && s_tready) begin
				predict_button(s_tdata[0], s_tdata[32:1], want);
				outcome_q.push_back(want);
			end
			if (cfg_wr_en) begin
				case (cfg_index)
				CFG_ACTIVE_HIGH: regs.active_high = cfg_data[0];
				CFG_DEBOUNCE:    regs.debounce_ms = cfg_data;
				CFG_CLICK_MAX:   regs.click_max_press_ms = cfg_data;
				CFG_DOUBLE_WIN:  regs.double_click_window_ms = cfg_data;
				default: ;
				endcase
			end
			pending = outcome_q.size();
		end
	end
endmodule

// ===== tb/sv/button_debounce_click_detector_tb.sv =====
// testbench top: clock, reset, stimulus and verdict for the button debounce and click detector
`timescale 1ns / 1ps
module button_debounce_click_detector_tb;
	import bdc_pkg::*;

	localparam int ITEMS_PER_PHASE = 200;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int DRAIN_CYCLES    = 8;
	localparam int LIMIT_NS        = 3000000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [39:0]      s_tdata = '0;    // [0] pin_level, [32:1] now_ms
	logic             m_tvalid;
	logic             m_tready = 1'b1;
	logic [7:0]       m_tdata;         // [2:0] event_res, [4:3] btn_state
	logic             cfg_wr_en = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	int          fail_count;
	int          pending;
	int          send_idle = 0;
	int          recv_stall = 0;
	bit          hold_req = 1'b0;
	int unsigned items_sent = 0;
	logic [31:0] clock_ms = '0;
	cfg_t        cur_cfg = '{RST_ACTIVE_HIGH, RST_DEBOUNCE, RST_CLICK_MAX, RST_DOUBLE_WIN};

	button_debounce_click_detector i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	button_debounce_click_detector_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#LIMIT_NS;
		$display("button_debounce_click_detector regression: fail");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int  left;
		bit  hold_done;
		left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				left = HOLD_OFF_CYCLES;
			end
			if (left > 0) begin
				m_tready = 1'b0;
				left--;
			end else begin
				m_tready = ($urandom_range(0, 99) >= recv_stall);
			end
		end
	end

	// offer one item and wait for it to be taken
	task automatic send_item(input logic pin, input logic [31:0] now);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {7'd0, now, pin};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// stop offering and let every expected result arrive
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// keep the button in one position for a while, sampling at random intervals
	task automatic hold_level(input bit down, input int unsigned dur, input int unsigned step_max);
		int unsigned spent;
		int unsigned stride;
		spent = 0;
		forever begin
			send_item(cur_cfg.active_high ? down : !down, clock_ms);
			if (spent >= dur)
				break;
			stride = $urandom_range(0, step_max);
			clock_ms += stride;
			spent += stride;
		end
	endtask

	// one press and release, with optional bounce on either edge
	task automatic gesture();
		int unsigned db;
		int unsigned cm;
		int unsigned dw;
		int unsigned step_max;
		int unsigned press_len;
		db = 32'(cur_cfg.debounce_ms);
		cm = 32'(cur_cfg.click_max_press_ms);
		dw = 32'(cur_cfg.double_click_window_ms);
		step_max = (db + cm + dw) / 8 + 1;
		if ($urandom_range(0, 1)) begin
			hold_level(1'b1, $urandom_range(0, db / 2), db / 4 + 1);
			hold_level(1'b0, $urandom_range(0, db / 2), db / 4 + 1);
		end
		if ($urandom_range(0, 3) == 0)
			press_len = cm + $urandom_range(0, cm / 4 + 4);
		else
			press_len = $urandom_range(0, cm);
		hold_level(1'b1, db + press_len, step_max);
		if ($urandom_range(0, 2) == 0) begin
			hold_level(1'b0, $urandom_range(0, db / 2), db / 4 + 1);
			hold_level(1'b1, $urandom_range(0, db / 2), db / 4 + 1);
		end
		hold_level(1'b0, db + $urandom_range(0, dw + dw / 2 + 4), step_max);
	endtask

	// new register setting and idling mode, then random gestures and noise
	task automatic run_phase(input logic ah, input int unsigned db, input int unsigned cm,
			input int unsigned dw, input int send_pct, input int recv_pct, input bit squeeze);
		int unsigned goal;
		int unsigned pick;
		settle();
		send_idle = send_pct;
		recv_stall = recv_pct;
		cur_cfg.active_high = ah;
		cur_cfg.debounce_ms = db[CFG_W-1:0];
		cur_cfg.click_max_press_ms = cm[CFG_W-1:0];
		cur_cfg.double_click_window_ms = dw[CFG_W-1:0];
		write_reg(CFG_ACTIVE_HIGH, {15'd0, ah});
		write_reg(CFG_DEBOUNCE, cur_cfg.debounce_ms);
		write_reg(CFG_CLICK_MAX, cur_cfg.click_max_press_ms);
		write_reg(CFG_DOUBLE_WIN, cur_cfg.double_click_window_ms);
		if (squeeze)
			hold_req = 1'b1;
		// start some phases just short of the counter wrap
		if ($urandom_range(0, 1))
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, db + cm + dw);
		goal = items_sent + ITEMS_PER_PHASE;
		while (items_sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				clock_ms = $urandom;
				send_item(1'($urandom_range(0, 1)), clock_ms);
			end else if (pick < 18) begin
				send_item(1'($urandom_range(0, 1)), clock_ms);
				clock_ms += $urandom_range(0, db / 4 + 1);
			end else begin
				gesture();
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, pin high means pressed
		send_item(1'b0, 32'd0);
		// bounce during press debounce falls back to idle
		send_item(1'b1, 32'd10);
		send_item(1'b1, 32'd30);
		send_item(1'b0, 32'd60);
		// short press arms a click
		send_item(1'b1, 32'd100);
		send_item(1'b1, 32'd150);
		send_item(1'b0, 32'd200);
		send_item(1'b0, 32'd250);
		// second short press inside the window: double click
		send_item(1'b1, 32'd300);
		send_item(1'b1, 32'd350);
		send_item(1'b0, 32'd400);
		send_item(1'b0, 32'd450);
		// long press: release only
		send_item(1'b1, 32'd500);
		send_item(1'b1, 32'd550);
		send_item(1'b0, 32'd1700);
		send_item(1'b0, 32'd1750);
		// single click reported after the window runs out
		send_item(1'b1, 32'd1800);
		send_item(1'b1, 32'd1850);
		send_item(1'b0, 32'd1900);
		send_item(1'b0, 32'd1950);
		send_item(1'b0, 32'd2300);
		// bounce during release debounce returns to pressed
		send_item(1'b1, 32'd2400);
		send_item(1'b1, 32'd2450);
		send_item(1'b0, 32'd2500);
		send_item(1'b1, 32'd2560);
		// release debounce across the counter wrap
		send_item(1'b0, 32'hFFFF_FFF0);
		send_item(1'b0, 32'h0000_0020);
		send_item(1'b0, 32'h0000_0030);
		clock_ms = 32'h0000_0040;

		// random phases over register settings and idling modes
		run_phase(1'b1, 50, 1000, 300, 0, 0, 1'b0);
		run_phase(1'b0, 50, 1000, 300, 62, 0, 1'b0);
		run_phase(1'b1, 0, 0, 0, 0, 62, 1'b0);
		run_phase(1'b0, 65535, 65535, 65535, 20, 20, 1'b0);
		run_phase(1'b1, 20, 120, 80, 0, 0, 1'b1);
		run_phase(1'b0, 3, 30, 20, 62, 0, 1'b0);
		run_phase(1'b1, 1, 65535, 0, 20, 20, 1'b0);
		run_phase(1'b0, 65535, 0, 65535, 0, 62, 1'b0);

		settle();
		if (fail_count == 0)
			$display("button_debounce_click_detector regression: pass");
		else
			$display("button_debounce_click_detector regression: fail");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bdc_pkg.sv
hw/rtl/bdc_cfg_regs.sv
hw/rtl/bdc_fsm.sv
hw/rtl/button_debounce_click_detector.sv
tb/sv/button_debounce_click_detector_checker.sv
tb/sv/button_debounce_click_detector_tb.sv
